### hw/rtl/ssh_pkg.sv
// Shared types, codes and constants of the shard site hash block.
// Used by the front end, the queue, the back end and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package ssh_pkg;

  localparam int MAX_SITES_DEF = 16;
  localparam int QUEUE_DEPTH   = 2;

  localparam int VALUE_W  = 64;
  localparam int SUM_W    = 5;
  localparam int SITE_W   = 16;
  localparam int TIDX_W   = 4;
  localparam int BUCKET_W = 4;
  localparam int CHUNK_W  = 4;

  localparam logic [CHUNK_W-1:0] CHUNKS_INT32  = 4'd4;
  localparam logic [CHUNK_W-1:0] CHUNKS_INT64  = 4'd8;
  localparam logic [CHUNK_W-1:0] CHUNKS_STRING = 4'd2;

  typedef enum logic [1:0] {
    KIND_INT32  = 2'd0,
    KIND_INT64  = 2'd1,
    KIND_DOUBLE = 2'd2,
    KIND_STRING = 2'd3
  } kind_t;

  typedef enum logic {
    CMD_ELEMENT = 1'b0,
    CMD_TABLE   = 1'b1
  } cmd_t;

  typedef enum logic [0:0] {
    CFG_SITE_COUNT  = 1'b0,
    CFG_HASH_METHOD = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_TABLE  = 2'd0,
    OP_ELEM   = 2'd1,
    OP_STRING = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    B_IDLE   = 3'd0,
    B_REDUCE = 3'd1,
    B_ADD    = 3'd2,
    B_READ   = 3'd3,
    B_OUT    = 3'd4
  } back_state_t;

  // One classified item on its way from the front end to the back end.
  typedef struct packed {
    op_t                 op;
    logic [VALUE_W-1:0]  operand;   // element left aligned, reduced one byte at a time; a string byte sits in bits 7:0
    logic [CHUNK_W-1:0]  chunks;
    logic                close;     // string element ends here
    logic                last;      // key ends here
    logic [TIDX_W-1:0]   tindex;
    logic [SITE_W-1:0]   tsite;
  } ent_t;

endpackage
`default_nettype wire

### hw/rtl/ssh_front.sv
// Front end: accepts input transfers, classifies them and forms the operand to reduce.
// Depends on ssh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ssh_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        cmd,
  input  wire logic [1:0]                  kind,
  input  wire logic [ssh_pkg::VALUE_W-1:0] value,
  input  wire logic                        end_of_value,
  input  wire logic                        end_of_key,
  input  wire logic [ssh_pkg::TIDX_W-1:0]  table_index,
  input  wire logic [ssh_pkg::SITE_W-1:0]  table_site,
  output ssh_pkg::ent_t                    ent,
  output logic                             ent_valid,
  input  wire logic                        ent_ready
);
  import ssh_pkg::*;

  // Magnitude of floor(x) for IEEE double bits, saturated to the int64 range.
  function automatic logic [63:0] floor_mag(input logic [63:0] bits);
    logic        neg;
    logic [10:0] e;
    logic [51:0] frac;
    logic [10:0] ex;
    logic [52:0] m;
    logic [5:0]  sh;
    logic [63:0] ip;
    logic        rest;
    neg  = bits[63];
    e    = bits[62:52];
    frac = bits[51:0];
    ex   = e - 11'd1023;
    m    = {1'b1, frac};
    ip   = '0;
    rest = 1'b0;
    if (e == 11'h7ff) begin
      if (frac != '0) ip = '0;
      else ip = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
    end else if (e < 11'd1023) begin
      ip = (neg && (e != '0 || frac != '0)) ? 64'd1 : 64'd0;
    end else if (ex >= 11'd63) begin
      ip = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
    end else begin
      if (ex >= 11'd52) begin
        ip = {11'b0, m} << (ex[5:0] - 6'd52);
      end else begin
        sh   = 6'd52 - ex[5:0];
        ip   = {11'b0, m >> sh};
        rest = (m & ~({53{1'b1}} << sh)) != '0;
      end
      if (neg && rest) ip = ip + 64'd1;
    end
    return ip;
  endfunction

  ent_t ent_in;

  assign in_ready = !ent_valid || ent_ready;

  always_comb begin
    ent_in.close  = end_of_value || end_of_key;
    ent_in.last   = end_of_key;
    ent_in.tindex = table_index;
    ent_in.tsite  = table_site;
    if (cmd_t'(cmd) == CMD_TABLE) begin
      ent_in.op      = OP_TABLE;
      ent_in.operand = '0;
      ent_in.chunks  = CHUNKS_STRING;
    end else begin
      unique case (kind_t'(kind))
        KIND_INT32: begin
          ent_in.op      = OP_ELEM;
          ent_in.operand = {value[31:0], 32'b0};
          ent_in.chunks  = CHUNKS_INT32;
        end
        KIND_INT64: begin
          ent_in.op      = OP_ELEM;
          ent_in.operand = value[63] ? (64'd0 - value) : value;
          ent_in.chunks  = CHUNKS_INT64;
        end
        KIND_DOUBLE: begin
          ent_in.op      = OP_ELEM;
          ent_in.operand = floor_mag(value);
          ent_in.chunks  = CHUNKS_INT64;
        end
        KIND_STRING: begin
          ent_in.op      = OP_STRING;
          ent_in.operand = {56'b0, value[7:0]};
          ent_in.chunks  = CHUNKS_STRING;
        end
        default: begin
          ent_in.op      = OP_ELEM;
          ent_in.operand = '0;
          ent_in.chunks  = CHUNKS_INT32;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
    end else if (in_ready) begin
      ent_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ent <= ent_in;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/ssh_queue.sv
// Short queue of classified items between the front end and the back end.
// Depends on ssh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ssh_queue (
  input  wire logic    clk,
  input  wire logic    rst,
  input  ssh_pkg::ent_t in_ent,
  input  wire logic    in_valid,
  output logic         in_ready,
  output ssh_pkg::ent_t out_ent,
  output logic         out_valid,
  input  wire logic    out_ready
);
  import ssh_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  ent_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign in_ready  = count != CW'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_ent   = slots[rp];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= (wp == PW'(QUEUE_DEPTH - 1)) ? '0 : wp + PW'(1);
      if (pop)  rp <= (rp == PW'(QUEUE_DEPTH - 1)) ? '0 : rp + PW'(1);
      if (push && !pop) count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= in_ent;
  end

endmodule
`default_nettype wire

### hw/rtl/ssh_back.sv
// Back end: byte-serial remainder unit, bucket and string sums, site table and result register.
// Depends on ssh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ssh_back #(
  parameter int MAX_SITES = ssh_pkg::MAX_SITES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  ssh_pkg::ent_t                     ent,
  input  wire logic                         ent_valid,
  output logic                              ent_ready,
  input  wire logic [ssh_pkg::SUM_W-1:0]    modulus,
  input  wire logic                         poly,
  output logic [ssh_pkg::SITE_W-1:0]        site,
  output logic [ssh_pkg::BUCKET_W-1:0]      bucket,
  output logic                              out_valid,
  input  wire logic                         out_ready
);
  import ssh_pkg::*;

  localparam int AW = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
  localparam logic [8:0] MAX9 = 9'(MAX_SITES);

  // Eight restoring steps: (r * 256 + chunk) mod n, for r below n.
  function automatic logic [SUM_W-1:0] reduce8(input logic [SUM_W-1:0] r,
                                               input logic [7:0] chunk,
                                               input logic [SUM_W-1:0] n);
    logic [SUM_W:0]   t;
    logic [SUM_W-1:0] acc;
    acc = r;
    for (int i = 7; i >= 0; i--) begin
      t = {acc, chunk[i]};
      if (t >= {1'b0, n}) t = t - {1'b0, n};
      acc = t[SUM_W-1:0];
    end
    return acc;
  endfunction

  back_state_t        state;
  back_state_t        state_next;
  op_t                op_r;
  logic               close_r;
  logic               last_r;
  logic [SUM_W-1:0]   acc;
  logic [63:0]        sh;
  logic [CHUNK_W-1:0] cnt;
  logic [SUM_W-1:0]   bucket_sum;
  logic [SUM_W-1:0]   string_sum;
  logic [SITE_W-1:0]  rd_data;
  logic [SITE_W-1:0]  mem [MAX_SITES];

  logic [SUM_W-1:0]   red_out;
  logic [SUM_W-1:0]   add_out;
  logic [SUM_W:0]     add_sum;
  logic [15:0]        s16;
  logic [15:0]        str_x;
  logic [8:0]         widx;
  logic [8:0]         ridx;
  logic               tbl_we;
  logic               load_out;
  logic               last_chunk;

  assign red_out    = reduce8(acc, sh[63:56], modulus);
  assign add_sum    = {1'b0, bucket_sum} + {1'b0, acc};
  assign add_out    = reduce8('0, {{(7 - SUM_W){1'b0}}, add_sum}, modulus);
  assign s16        = {{(16 - SUM_W){1'b0}}, string_sum};
  // The held string sum may exceed a smaller modulus; the remainder step absorbs that.
  assign str_x      = poly ? ((s16 << 7) - s16 + {8'b0, ent.operand[7:0]})
                           : (s16 + {8'b0, ent.operand[7:0]});
  assign widx       = {{(9 - TIDX_W){1'b0}}, ent.tindex};
  assign ridx       = {{(9 - SUM_W){1'b0}}, bucket_sum};
  assign last_chunk = cnt == CHUNK_W'(1);
  assign tbl_we     = state == B_IDLE && ent_valid && ent.op == OP_TABLE && widx < MAX9;
  assign load_out   = state == B_OUT && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    ent_ready  = 1'b0;
    unique case (state)
      B_IDLE: begin
        ent_ready = 1'b1;
        if (ent_valid && (ent.op == OP_ELEM || ent.op == OP_STRING)) state_next = B_REDUCE;
      end
      B_REDUCE: begin
        if (last_chunk) begin
          if (op_r == OP_STRING && !close_r) state_next = B_IDLE;
          else state_next = B_ADD;
        end
      end
      B_ADD:  state_next = last_r ? B_READ : B_IDLE;
      B_READ: state_next = B_OUT;
      B_OUT:  if (load_out) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        if (ent_valid) begin
          op_r    <= ent.op;
          close_r <= ent.close;
          last_r  <= ent.last;
          acc     <= '0;
          if (ent.op == OP_STRING) begin
            sh  <= {str_x, 48'b0};
            cnt <= CHUNKS_STRING;
          end else begin
            sh  <= ent.operand;
            cnt <= ent.chunks;
          end
        end
      end
      B_REDUCE: begin
        acc <= red_out;
        sh  <= sh << 8;
        cnt <= cnt - CHUNK_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_sum <= '0;
      string_sum <= '0;
    end else begin
      unique case (state)
        B_REDUCE: if (last_chunk && op_r == OP_STRING) string_sum <= red_out;
        B_ADD: begin
          bucket_sum <= add_out;
          if (op_r == OP_STRING) string_sum <= '0;
        end
        B_OUT: begin
          if (load_out) begin
            bucket_sum <= '0;
            string_sum <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) mem[widx[AW-1:0]] <= ent.tsite;
    if (state == B_READ) rd_data <= mem[ridx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      site   <= rd_data;
      bucket <= bucket_sum[BUCKET_W-1:0];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/shard_site_hash.sv
// Path: front register, queue, then the back end: a table write is taken in the idle state;
// an element or string byte is reduced in the reduce state, then an element or closing string
// byte is summed in the add state; a key end then passes the table read and result states.
// Throughput is set by the back end's remainder unit: 8 operand bits a cycle while reducing.
// Reset clears the control state, both sums and the configuration (site_count 1, byte sum);
// the site table is not cleared and holds nothing meaningful until written.
`timescale 1ns / 1ps
`default_nettype none
module shard_site_hash #(
  parameter int MAX_SITES = ssh_pkg::MAX_SITES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [87:0] s_tdata,  // value[63:0], table_index[67:64], table_site[83:68], zero
  input  wire logic [3:0]  s_tuser,  // cmd[0], kind[2:1], end_of_value[3]
  input  wire logic        s_tlast,  // end_of_key
  // Result stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,  // site[15:0], bucket[19:16], zero
  // Configuration writes.
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [4:0]  cfg_data
);
  import ssh_pkg::*;

  localparam logic [8:0] MAX9 = 9'(MAX_SITES);

  logic [SUM_W-1:0]    site_count;
  logic                hash_method;
  logic [SUM_W-1:0]    modulus;
  logic [8:0]          sc9;
  ent_t                f_ent;
  logic                f_valid;
  logic                f_ready;
  ent_t                q_ent;
  logic                q_valid;
  logic                q_ready;
  logic [SITE_W-1:0]   site;
  logic [BUCKET_W-1:0] bucket;

  // Configuration registers. A site count of zero behaves as one; a count above the
  // table depth behaves as the table depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      site_count  <= SUM_W'(1);
      hash_method <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SITE_COUNT:  site_count  <= cfg_data;
        CFG_HASH_METHOD: hash_method <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign sc9     = {{(9 - SUM_W){1'b0}}, site_count};
  assign modulus = (site_count == '0) ? SUM_W'(1)
                 : (sc9 > MAX9) ? MAX9[SUM_W-1:0] : site_count;

  // The front end classifies each transfer; table writes travel through the queue too so
  // that they stay ordered with the table reads of earlier keys.
  ssh_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .cmd          (s_tuser[0]),
    .kind         (s_tuser[2:1]),
    .value        (s_tdata[63:0]),
    .end_of_value (s_tuser[3]),
    .end_of_key   (s_tlast),
    .table_index  (s_tdata[67:64]),
    .table_site   (s_tdata[83:68]),
    .ent          (f_ent),
    .ent_valid    (f_valid),
    .ent_ready    (f_ready)
  );

  ssh_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_ent    (f_ent),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .out_ent   (q_ent),
    .out_valid (q_valid),
    .out_ready (q_ready)
  );

  // The back end holds the result in its own register, so it keeps draining the queue
  // while a finished result waits for the downstream side.
  ssh_back #(
    .MAX_SITES (MAX_SITES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .ent       (q_ent),
    .ent_valid (q_valid),
    .ent_ready (q_ready),
    .modulus   (modulus),
    .poly      (hash_method),
    .site      (site),
    .bucket    (bucket),
    .out_valid (m_tvalid),
    .out_ready (m_tready)
  );

  assign m_tdata = {4'b0, bucket, site};

endmodule
`default_nettype wire
